// ----- src/acr_pkg.sv -----
package acr_pkg;

  localparam int TABLE_DEPTH_DEF = 128;

  // input commands
  localparam logic [1:0] CMD_LOOKUP   = 2'd0;
  localparam logic [1:0] CMD_PACKET   = 2'd1;
  localparam logic [1:0] CMD_ANNOUNCE = 2'd2;
  localparam logic [1:0] CMD_CLEAR    = 2'd3;

  // result kinds
  localparam logic [2:0] K_HIT       = 3'd0;
  localparam logic [2:0] K_MISS      = 3'd1;
  localparam logic [2:0] K_REPLY     = 3'd2;
  localparam logic [2:0] K_STORED    = 3'd3;
  localparam logic [2:0] K_FULL      = 3'd4;
  localparam logic [2:0] K_IGNORED   = 3'd5;
  localparam logic [2:0] K_ANNOUNCED = 3'd6;
  localparam logic [2:0] K_CLEARED   = 3'd7;

  // frame operation codes
  localparam logic [1:0]  TX_NONE    = 2'd0;
  localparam logic [1:0]  TX_REQUEST = 2'd1;
  localparam logic [1:0]  TX_REPLY   = 2'd2;
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;

  localparam logic [47:0] BCAST_MAC = 48'hffff_ffff_ffff;

  // register select (paddr bit 3)
  localparam logic REG_OWN_MAC = 1'b0;
  localparam logic REG_OWN_IP  = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] lookup_ip;
    logic [15:0] pkt_operation;
    logic [47:0] pkt_sender_mac;
    logic [31:0] pkt_sender_ip;
    logic [31:0] pkt_target_ip;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [47:0] found_mac;
    logic [1:0]  tx_operation;
    logic [47:0] tx_dest_mac;
    logic [47:0] tx_target_mac;
    logic [31:0] tx_target_ip;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       start;
    logic       scan;
    logic       load;
    logic [2:0] kind;
  } acr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic       tgt_match;
    logic       op_req;
    logic       full;
    logic       hit;
    logic       scan_end;
  } acr_sts_t;

endpackage

// ----- src/arp_cache_and_responder_core.sv -----
// channel   | direction | handshake           | payload
// in_*      | input     | in_valid / in_stall   | in_item_t (command and packet fields)
// out_*     | output    | out_valid / out_stall | out_item_t (result kind and tx fields)
// apb       | input     | psel / penable / pready | own_mac at 0x0, own_ip at 0x8
//
// one item at a time; a lookup walks the valid entries one per cycle through
// the registered table read and stops early when it hits; every other command
// skips the scan and goes straight to the result
// reset clears entry count, config registers and the output valid; no clearing pass
// out_stall holds the result register; a new item is still taken while it waits,
// and finishes once the register is free
module arp_cache_and_responder_core
  import acr_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  // apb config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  acr_cmd_t ctl;
  acr_sts_t sts;
  logic     cfg_wr;

  // register written on the access phase of a write transfer
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  // sequencer: idle, table scan, result hand-off
  acr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_data.command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sts        (sts),
    .ctl        (ctl)
  );

  // item register, ip/mac tables, compare, config and result register
  acr_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .cfg_wr    (cfg_wr),
    .cfg_sel   (paddr[3]),
    .cfg_wdata (pwdata),
    .cfg_rdata (prdata),
    .res_data  (out_data)
  );

endmodule

// ----- src/acr_dp.sv -----
module acr_dp
  import acr_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_data,
  input  acr_cmd_t    ctl,
  output acr_sts_t    sts,
  input  logic        cfg_wr,
  input  logic        cfg_sel,
  input  logic [63:0] cfg_wdata,
  output logic [63:0] cfg_rdata,
  output out_item_t   res_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  logic [31:0] ip_mem  [TABLE_DEPTH];
  logic [47:0] mac_mem [TABLE_DEPTH];

  in_item_t    item_r;
  logic [47:0] own_mac_r;
  logic [31:0] own_ip_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rd_idx_r;
  logic        pend_r;
  logic [31:0] ip_rd_r;
  logic [47:0] mac_rd_r;
  out_item_t   res_r, res_nxt;
  logic        hit_c, issue, wr_en;

  assign hit_c = pend_r && (ip_rd_r == item_r.lookup_ip);
  assign issue = ctl.scan && !hit_c && (rd_idx_r != count_r);
  assign wr_en = ctl.load && (ctl.kind == K_STORED);

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      item_r <= in_data;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r <= '0;
      own_ip_r  <= '0;
    end else if (cfg_wr) begin
      if (cfg_sel == REG_OWN_IP) begin
        own_ip_r <= cfg_wdata[31:0];
      end else begin
        own_mac_r <= cfg_wdata[47:0];
      end
    end
  end

  assign cfg_rdata = (cfg_sel == REG_OWN_IP) ? {32'd0, own_ip_r} : {16'd0, own_mac_r};

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (ctl.load && (ctl.kind == K_STORED)) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.load && (ctl.kind == K_CLEARED)) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // scan pointer and read pipeline flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
      pend_r   <= 1'b0;
    end else if (ctl.start) begin
      rd_idx_r <= '0;
      pend_r   <= 1'b0;
    end else begin
      pend_r <= issue;
      if (issue) begin
        rd_idx_r <= rd_idx_r + CW'(1);
      end
    end
  end

  // table memories
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ip_mem[count_r[AW-1:0]]  <= item_r.pkt_sender_ip;
      mac_mem[count_r[AW-1:0]] <= item_r.pkt_sender_mac;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      ip_rd_r  <= ip_mem[rd_idx_r[AW-1:0]];
      mac_rd_r <= mac_mem[rd_idx_r[AW-1:0]];
    end
  end

  // result build
  always_comb begin
    res_nxt             = '0;
    res_nxt.result_kind = ctl.kind;
    case (ctl.kind)
      K_HIT: begin
        res_nxt.found_mac = mac_rd_r;
      end
      K_MISS: begin
        res_nxt.tx_operation = TX_REQUEST;
        res_nxt.tx_dest_mac  = BCAST_MAC;
        res_nxt.tx_target_ip = item_r.lookup_ip;
      end
      K_REPLY: begin
        res_nxt.tx_operation  = TX_REPLY;
        res_nxt.tx_dest_mac   = item_r.pkt_sender_mac;
        res_nxt.tx_target_mac = item_r.pkt_sender_mac;
        res_nxt.tx_target_ip  = item_r.pkt_sender_ip;
      end
      K_ANNOUNCED: begin
        res_nxt.tx_operation = TX_REPLY;
        res_nxt.tx_dest_mac  = BCAST_MAC;
        res_nxt.tx_target_ip = own_ip_r;
      end
      default: begin
        res_nxt.tx_operation = TX_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      res_r <= res_nxt;
    end
  end

  assign res_data = res_r;

  assign sts.command   = item_r.command;
  assign sts.tgt_match = (item_r.pkt_target_ip == own_ip_r);
  assign sts.op_req    = (item_r.pkt_operation == ARP_OP_REQUEST);
  assign sts.full      = (count_r == FULL_COUNT);
  assign sts.hit       = hit_c;
  assign sts.scan_end  = !pend_r && (rd_idx_r == count_r);

endmodule

// ----- src/acr_ctrl.sv -----
module acr_ctrl
  import acr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  output logic       out_valid,
  input  logic       out_stall,
  input  acr_sts_t   sts,
  output acr_cmd_t   ctl
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_RESULT = 3'b100
  } state_t;

  state_t     state_r, state_nxt;
  logic       hit_r, hit_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept, out_free;
  logic [2:0] kind_c;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    case (sts.command)
      CMD_LOOKUP: begin
        kind_c = hit_r ? K_HIT : K_MISS;
      end
      CMD_PACKET: begin
        if (!sts.tgt_match) begin
          kind_c = K_IGNORED;
        end else if (sts.op_req) begin
          kind_c = K_REPLY;
        end else if (sts.full) begin
          kind_c = K_FULL;
        end else begin
          kind_c = K_STORED;
        end
      end
      CMD_ANNOUNCE: begin
        kind_c = K_ANNOUNCED;
      end
      default: begin
        kind_c = K_CLEARED;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    hit_nxt   = hit_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_command == CMD_LOOKUP) ? S_SCAN : S_RESULT;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          hit_nxt   = 1'b1;
          state_nxt = S_RESULT;
        end else if (sts.scan_end) begin
          hit_nxt   = 1'b0;
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ctl.start = accept;
  assign ctl.scan  = (state_r == S_SCAN);
  assign ctl.load  = (state_r == S_RESULT) && out_free;
  assign ctl.kind  = kind_c;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- src/acr_chk.sv -----
module acr_chk
  import acr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one item in flight: busy right after a transfer in
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // a new result only appears after the block was busy with an item
  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without an item");

  // a miss carries a broadcast request
  a_miss_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == K_MISS) |->
      (out_data.tx_operation == TX_REQUEST) && (out_data.tx_dest_mac == BCAST_MAC))
    else $error("miss without broadcast request");

  // reset clears the output valid
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind arp_cache_and_responder_core acr_chk u_acr_chk (.*);

// ----- tb/arp_cache_and_responder_core_tb.sv -----
module arp_cache_and_responder_core_tb;
  import acr_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 6;
  localparam int MAX_WAIT     = 12;
  localparam int FILL_LIMIT   = TABLE_DEPTH_DEF;
  // settle time outlasts a lookup over a full table
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam logic [3:0]  ADDR_OWN_MAC = {REG_OWN_MAC, 3'b000};
  localparam logic [3:0]  ADDR_OWN_IP  = {REG_OWN_IP, 3'b000};
  localparam logic [15:0] ARP_OP_REPLY = 16'd2;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  arp_cache_and_responder_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // shadow of the cache: entries, fill level and the interface addresses
  logic [31:0] cache_ip [FILL_LIMIT];
  logic [47:0] cache_mac [FILL_LIMIT];
  int          cache_fill = 0;
  logic [47:0] own_mac_q = '0;
  logic [31:0] own_ip_q = '0;

  // responses predicted for accepted transfers, oldest first
  out_item_t   pending_responses[$];
  int          fail_count = 0;

  // addresses reused across items so that lookups hit and appends duplicate
  logic [31:0] ip_pool [16];

  // idling controls, shared between the stimulus and the receiver process
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int          rx_hold = 0;

  // ---------------------------------------------------------------------------
  // cache behavior: works out the response to one accepted command and
  // updates the shadow table the same way the block does
  // ---------------------------------------------------------------------------
  function automatic out_item_t resolve_arp(input in_item_t it);
    out_item_t r;
    bit        found;
    r = '0;
    found = 1'b0;
    case (it.command)
      CMD_LOOKUP: begin
        // first matching entry wins, so a duplicate IP never shadows the original
        for (int e = 0; e < cache_fill && !found; e++) begin
          if (cache_ip[e] == it.lookup_ip) begin
            found = 1'b1;
            r.result_kind = K_HIT;
            r.found_mac = cache_mac[e];
          end
        end
        if (!found) begin
          // miss: broadcast request for the address
          r.result_kind = K_MISS;
          r.tx_operation = TX_REQUEST;
          r.tx_dest_mac = BCAST_MAC;
          r.tx_target_ip = it.lookup_ip;
        end
      end
      CMD_PACKET: begin
        if (it.pkt_target_ip != own_ip_q) begin
          r.result_kind = K_IGNORED;
        end else if (it.pkt_operation == ARP_OP_REQUEST) begin
          // unicast reply to the asker, the asker is not learned
          r.result_kind = K_REPLY;
          r.tx_operation = TX_REPLY;
          r.tx_dest_mac = it.pkt_sender_mac;
          r.tx_target_mac = it.pkt_sender_mac;
          r.tx_target_ip = it.pkt_sender_ip;
        end else if (cache_fill >= FILL_LIMIT) begin
          // append to a full table is dropped
          r.result_kind = K_FULL;
        end else begin
          cache_ip[cache_fill] = it.pkt_sender_ip;
          cache_mac[cache_fill] = it.pkt_sender_mac;
          cache_fill++;
          r.result_kind = K_STORED;
        end
      end
      CMD_ANNOUNCE: begin
        // gratuitous reply, broadcast, target is our own address
        r.result_kind = K_ANNOUNCED;
        r.tx_operation = TX_REPLY;
        r.tx_dest_mac = BCAST_MAC;
        r.tx_target_ip = own_ip_q;
      end
      default: begin
        cache_fill = 0;
        r.result_kind = K_CLEARED;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // random helpers
  // ---------------------------------------------------------------------------
  function automatic logic [47:0] rand_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  function automatic int draw_wait(input bit on);
    return on ? $urandom_range(0, MAX_WAIT) : 0;
  endfunction

  // every field random, command included
  function automatic in_item_t noise_item();
    in_item_t it;
    it.command = 2'($urandom_range(0, 3));
    it.lookup_ip = $urandom();
    it.pkt_operation = 16'($urandom_range(0, 16'hffff));
    it.pkt_sender_mac = rand_mac();
    it.pkt_sender_ip = $urandom();
    it.pkt_target_ip = $urandom();
    return it;
  endfunction

  // an address likely to be in the table, often deep in it
  function automatic logic [31:0] known_ip();
    if (cache_fill > 0 && $urandom_range(0, 1) == 0)
      return cache_ip[$urandom_range(0, cache_fill - 1)];
    return ip_pool[$urandom_range(0, 15)];
  endfunction

  function automatic void refill_pool();
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    for (int i = 2; i < 16; i++) ip_pool[i] = $urandom();
  endfunction

  // mostly well-formed traffic addressed to us, with a little raw noise
  function automatic in_item_t traffic_item(input int clear_w);
    in_item_t it;
    int       r;
    it = noise_item();
    if ($urandom_range(0, 99) < 4) begin
      // noise must not wipe the table in phases meant to fill it
      if (clear_w == 0 && it.command == CMD_CLEAR) it.command = CMD_LOOKUP;
      return it;
    end
    r = $urandom_range(0, 99);
    if (r < clear_w) begin
      it.command = CMD_CLEAR;
    end else if (r < clear_w + 5) begin
      it.command = CMD_ANNOUNCE;
    end else if (r < 50) begin
      it.command = CMD_LOOKUP;
      if ($urandom_range(0, 9) < 7) it.lookup_ip = known_ip();
    end else begin
      it.command = CMD_PACKET;
      if ($urandom_range(0, 9) != 0) it.pkt_target_ip = own_ip_q;
      if ($urandom_range(0, 2) == 0) begin
        it.pkt_operation = ARP_OP_REQUEST;
      end else begin
        case ($urandom_range(0, 3))
          0: it.pkt_operation = ARP_OP_REPLY;
          1: it.pkt_operation = 16'h0000;
          2: it.pkt_operation = 16'hffff;
          default: ;
        endcase
      end
      if ($urandom_range(0, 3) != 0) it.pkt_sender_ip = ip_pool[$urandom_range(0, 15)];
    end
    return it;
  endfunction

  function automatic in_item_t lookup_cmd(input logic [31:0] ip);
    in_item_t it;
    it = noise_item();
    it.command = CMD_LOOKUP;
    it.lookup_ip = ip;
    return it;
  endfunction

  function automatic in_item_t packet_cmd(input logic [15:0] op, input logic [47:0] smac,
                                          input logic [31:0] sip, input logic [31:0] tip);
    in_item_t it;
    it = noise_item();
    it.command = CMD_PACKET;
    it.pkt_operation = op;
    it.pkt_sender_mac = smac;
    it.pkt_sender_ip = sip;
    it.pkt_target_ip = tip;
    return it;
  endfunction

  function automatic in_item_t simple_cmd(input logic [1:0] cmd);
    in_item_t it;
    it = noise_item();
    it.command = cmd;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // input channel: one transfer per call; valid stays high into the next call
  // when there is no gap, so it is never lowered and raised in one step
  // ---------------------------------------------------------------------------
  task automatic send_command(input in_item_t it);
    int gap;
    gap = draw_wait(tx_idle_on);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    pending_responses.push_back(resolve_arp(it));
  endtask

  // drop valid and wait until every predicted response has been seen
  task automatic drain_responses();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  // config port write: setup cycle, then access cycle until pready
  task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[3] == REG_OWN_IP) own_ip_q = data[31:0];
    else own_mac_q = data[47:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_interface(input logic [47:0] mac, input logic [31:0] ip);
    apb_write(ADDR_OWN_MAC, {16'h0000, mac});
    apb_write(ADDR_OWN_IP, {32'h0, ip});
  endtask

  // ---------------------------------------------------------------------------
  // result channel: receiver stalls a random number of cycles per transfer,
  // or a long hold when one is requested
  // ---------------------------------------------------------------------------
  initial begin : result_receiver
    int n;
    forever begin
      @(negedge clk);
      n = draw_wait(rx_idle_on);
      if (rx_hold > 0) begin
        n = rx_hold;
        rx_hold = 0;
      end
      repeat (n) begin
        out_stall <= 1'b1;
        @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic compare_response(input out_item_t exp, input out_item_t got);
    if (got.result_kind !== exp.result_kind) begin
      $error("result_kind: expected %0d, got %0d", exp.result_kind, got.result_kind);
      fail_count++;
    end
    if (got.found_mac !== exp.found_mac) begin
      $error("found_mac: expected %h, got %h", exp.found_mac, got.found_mac);
      fail_count++;
    end
    if (got.tx_operation !== exp.tx_operation) begin
      $error("tx_operation: expected %0d, got %0d", exp.tx_operation, got.tx_operation);
      fail_count++;
    end
    if (got.tx_dest_mac !== exp.tx_dest_mac) begin
      $error("tx_dest_mac: expected %h, got %h", exp.tx_dest_mac, got.tx_dest_mac);
      fail_count++;
    end
    if (got.tx_target_mac !== exp.tx_target_mac) begin
      $error("tx_target_mac: expected %h, got %h", exp.tx_target_mac, got.tx_target_mac);
      fail_count++;
    end
    if (got.tx_target_ip !== exp.tx_target_ip) begin
      $error("tx_target_ip: expected %h, got %h", exp.tx_target_ip, got.tx_target_ip);
      fail_count++;
    end
  endtask

  // every result transfer is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_responses.size() == 0) begin
        $error("result_kind: expected no transfer, got %0d", out_data.result_kind);
        fail_count++;
      end else begin
        compare_response(pending_responses.pop_front(), out_data);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, every command and the corner cases of the cache
  task automatic test_directed_cases();
    logic [31:0] addr_a;
    logic [47:0] mac_a;
    addr_a = 32'hc0a8_0a17;
    mac_a = 48'h0200_5e10_2233;
    set_interface(48'h0012_3456_789a, 32'hc0a8_0001);
    // empty table: lookup misses and sends a broadcast request
    send_command(lookup_cmd(32'hffff_ffff));
    // not addressed to us
    send_command(packet_cmd(ARP_OP_REPLY, mac_a, addr_a, 32'hc0a8_0002));
    // request to us: unicast reply, asker not learned
    send_command(packet_cmd(ARP_OP_REQUEST, 48'hffff_ffff_ffff, 32'h0, own_ip_q));
    send_command(lookup_cmd(32'h0));
    // learn, then learn the same address again with another mac
    send_command(packet_cmd(ARP_OP_REPLY, mac_a, addr_a, own_ip_q));
    send_command(packet_cmd(16'hffff, 48'hffff_ffff_ffff, addr_a, own_ip_q));
    send_command(packet_cmd(16'h0000, 48'h0, 32'h0, own_ip_q));
    send_command(packet_cmd(16'h0002, 48'hffff_ffff_ffff, 32'hffff_ffff, own_ip_q));
    // earliest duplicate wins
    send_command(lookup_cmd(addr_a));
    send_command(lookup_cmd(32'h0));
    send_command(lookup_cmd(32'hffff_ffff));
    send_command(lookup_cmd(32'hffff_fffe));
    send_command(simple_cmd(CMD_ANNOUNCE));
    // clear empties the table, the old entries are gone
    send_command(simple_cmd(CMD_CLEAR));
    send_command(lookup_cmd(addr_a));
    send_command(simple_cmd(CMD_CLEAR));
    drain_responses();
  endtask

  // fill every slot, overflow it, and scan to the deepest entry
  task automatic test_table_full();
    logic [31:0] last_ip;
    last_ip = '0;
    refill_pool();
    send_command(simple_cmd(CMD_CLEAR));
    while (cache_fill < FILL_LIMIT) begin
      last_ip = ($urandom_range(0, 3) == 0) ? ip_pool[$urandom_range(0, 15)] : $urandom();
      send_command(packet_cmd(ARP_OP_REPLY, rand_mac(), last_ip, own_ip_q));
    end
    // appends to a full table are dropped, requests are still answered
    repeat (3) send_command(packet_cmd(ARP_OP_REPLY, rand_mac(), $urandom(), own_ip_q));
    send_command(packet_cmd(ARP_OP_REQUEST, rand_mac(), $urandom(), own_ip_q));
    send_command(lookup_cmd(last_ip));
    send_command(lookup_cmd(cache_ip[FILL_LIMIT - 1]));
    send_command(lookup_cmd($urandom()));
    drain_responses();
  endtask

  // receiver holds off long enough that the block fills and stalls its input
  task automatic test_input_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    refill_pool();
    rx_hold = HOLD_CYCLES;
    send_command(simple_cmd(CMD_CLEAR));
    repeat (40) send_command(traffic_item(2));
    drain_responses();
  endtask

  // random traffic under one interface setting and one idling mix
  task automatic test_mixed_traffic(input logic [47:0] mac, input logic [31:0] ip,
                                    input int count, input int clear_w,
                                    input bit tx_idle, input bit rx_idle);
    set_interface(mac, ip);
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
    refill_pool();
    repeat (count) send_command(traffic_item(clear_w));
    drain_responses();
  endtask

  initial begin : run_tests
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_table_full();
    // table stays full: deep scans and dropped appends
    test_mixed_traffic('1, '1, 380, 0, 1'b1, 1'b1);
    test_input_backpressure();
    // no idling on either side
    test_mixed_traffic('0, '0, 380, 2, 1'b0, 1'b0);
    test_mixed_traffic(rand_mac(), $urandom(), 420, 1, 1'b1, 1'b0);
    test_mixed_traffic(rand_mac(), $urandom(), 420, 0, 1'b0, 1'b1);
    test_mixed_traffic(rand_mac(), $urandom(), 300, 3, 1'b1, 1'b1);

    // let anything stray come out before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_responses.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hard limit well beyond the slowest legal run
  initial begin : watchdog
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
